### sv/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Widths, phase codes, register indexes and the structs that travel between
// the front end, the divider cells and the top level.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // Counter width for the phase lengths and fraction bits of a level.
    localparam int CW  = 32;
    localparam int LF  = 16;
    localparam int LW  = LF + 1;
    // Fixed field widths.
    localparam int P_W     = 34;
    localparam int SUS_W   = 17;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 2;
    localparam int PHASE_W = 3;
    localparam int LEVEL_W = 17;
    // Width of the partial remainder and divisor in the divider chain.
    localparam int REM_W = CW + LF;
    // Width in which positions are compared against the phase boundaries.
    localparam int CMP_W = (P_W > CW + 3) ? P_W : CW + 3;
    // Width in which the sustain level is saturated.
    localparam int SAT_W = (SUS_W > LW) ? SUS_W : LW;

    localparam logic [LW-1:0] FULL = {1'b1, {LF{1'b0}}};

    // Phase codes.
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

    // Register indexes.
    localparam logic [IDX_W-1:0] IDX_ATTACK  = 2'd0;
    localparam logic [IDX_W-1:0] IDX_DECAY   = 2'd1;
    localparam logic [IDX_W-1:0] IDX_RELEASE = 2'd2;
    localparam logic [IDX_W-1:0] IDX_SUSTAIN = 2'd3;

    typedef struct packed {
        logic [CW-1:0]    attack;
        logic [CW-1:0]    decay;
        logic [CW-1:0]    release_len;
        logic [SUS_W-1:0] sustain;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LW-1:0]      base;
    } side_t;

    typedef struct packed {
        logic          valid;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dsh;
        logic [LW-1:0] quot;
        side_t         side;
    } cell_t;

endpackage

### sv/adsr_front.sv
// ----------------------------------------------------------------------------
// ADSR front end
// Finds the phase of each word, forms the dividend and divisor for the
// ramp and hands the first cell of the divider chain its operands.
// ----------------------------------------------------------------------------
module adsr_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [adsr_pkg::P_W-1:0]   position,
    input  logic [adsr_pkg::CW-1:0]    sus_len,
    input  adsr_pkg::cfg_t             cfg,
    output adsr_pkg::cell_t            cell_out
);
    import adsr_pkg::*;

    // Stage 1: registered input word.
    logic             v1_reg;
    logic [P_W-1:0]   p1_reg;
    logic [CW-1:0]    l1_reg;

    // Stage 2: boundaries of decay and sustain.
    logic             v2_reg;
    logic [CMP_W-1:0] p2_reg;
    logic [CMP_W-1:0] ad2_reg;
    logic [CMP_W-1:0] t22_reg;
    logic             lta2_reg;
    logic [CMP_W-1:0] ad_next;
    logic [CMP_W-1:0] t2_next;
    logic             lta_next;

    // Stage 3: phase and operands of the multiply.
    logic               v3_reg;
    logic [PHASE_W-1:0] ph3_reg;
    logic [CW-1:0]      x3_reg;
    logic [LW-1:0]      m3_reg;
    logic [CW-1:0]      den3_reg;
    logic [LW-1:0]      s3_reg;
    logic [CMP_W-1:0]   t3;
    logic [CMP_W-1:0]   x_dec;
    logic [CMP_W-1:0]   x_rel;
    logic [LW-1:0]      s_sat;
    logic [PHASE_W-1:0] ph_next;
    logic [CW-1:0]      x_next;
    logic [LW-1:0]      m_next;
    logic [CW-1:0]      den_next;

    // Stage 4: product and first divider word.
    logic [CW+LW-1:0]   prod_full;
    cell_t              cell_next;
    logic               v4_reg;
    cell_t              cell_reg;

    // Valid bits along the front end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= position;
            l1_reg <= sus_len;
        end
    end

    // Stage 2: end of decay and end of sustain, and the attack test.
    always_comb
    begin
        ad_next  = CMP_W'(cfg.attack) + CMP_W'(cfg.decay);
        t2_next  = ad_next + CMP_W'(l1_reg);
        lta_next = CMP_W'(p1_reg) < CMP_W'(cfg.attack);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg   <= CMP_W'(p1_reg);
            ad2_reg  <= ad_next;
            t22_reg  <= t2_next;
            lta2_reg <= lta_next;
        end
    end

    // Stage 3: pick the phase and the ramp operands.
    always_comb
    begin
        t3    = t22_reg + CMP_W'(cfg.release_len);
        x_dec = p2_reg - CMP_W'(cfg.attack);
        x_rel = t3 - p2_reg;
        if (SAT_W'(cfg.sustain) > SAT_W'(FULL))
        begin
            s_sat = FULL;
        end
        else
        begin
            s_sat = LW'(cfg.sustain);
        end

        ph_next  = PH_DONE;
        x_next   = '0;
        m_next   = '0;
        den_next = '0;
        if (lta2_reg)
        begin
            ph_next  = PH_ATTACK;
            x_next   = p2_reg[CW-1:0];
            m_next   = FULL;
            den_next = cfg.attack;
        end
        else if (p2_reg < ad2_reg)
        begin
            ph_next  = PH_DECAY;
            x_next   = x_dec[CW-1:0];
            m_next   = FULL - s_sat;
            den_next = cfg.decay;
        end
        else if (p2_reg < t22_reg)
        begin
            ph_next = PH_SUSTAIN;
        end
        else if (p2_reg < t3)
        begin
            ph_next  = PH_RELEASE;
            x_next   = x_rel[CW-1:0];
            m_next   = s_sat;
            den_next = cfg.release_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph3_reg  <= ph_next;
            x3_reg   <= x_next;
            m3_reg   <= m_next;
            den3_reg <= den_next;
            s3_reg   <= s_sat;
        end
    end

    // Stage 4: one multiply, then the divisor aligned to the top quotient bit.
    always_comb
    begin
        prod_full            = {{LW{1'b0}}, x3_reg} * {{CW{1'b0}}, m3_reg};
        cell_next.valid      = v3_reg;
        cell_next.rem        = prod_full[REM_W-1:0];
        cell_next.dsh        = {den3_reg, {LF{1'b0}}};
        cell_next.quot       = '0;
        cell_next.side.phase = ph3_reg;
        cell_next.side.base  = s3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    always_comb
    begin
        cell_out       = cell_reg;
        cell_out.valid = v4_reg;
    end

endmodule

### sv/adsr_div_cell.sv
// ----------------------------------------------------------------------------
// ADSR divider cell
// One restoring division step: decides one quotient bit and hands the
// remainder and the halved divisor to the next cell.
// ----------------------------------------------------------------------------
module adsr_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  adsr_pkg::cell_t cell_in,
    output adsr_pkg::cell_t cell_out
);
    import adsr_pkg::*;

    logic  ge;
    cell_t cell_next;
    cell_t cell_reg;
    logic  valid_reg;

    // Trial subtraction and quotient bit.
    always_comb
    begin
        ge             = cell_in.rem >= cell_in.dsh;
        cell_next      = cell_in;
        cell_next.rem  = ge ? (cell_in.rem - cell_in.dsh) : cell_in.rem;
        cell_next.dsh  = cell_in.dsh >> 1;
        cell_next.quot = {cell_in.quot[LW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    always_comb
    begin
        cell_out       = cell_reg;
        cell_out.valid = valid_reg;
    end

endmodule

### sv/adsr_envelope_level.sv
// ----------------------------------------------------------------------------
// ADSR envelope level
// Linear attack, decay, sustain and release level for a sample position,
// computed by a front end and a chain of restoring division cells.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -----------------------------------------
//  in       in_valid / in_stall    position, sustain_length
//  out      out_valid / out_stall  level, phase, done_res
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is accepted every cycle while the chain is not held; the pipeline has four
// front-end stages, one division cell per quotient bit (17) and the output register.
// Reset clears every valid bit and loads the registers with their defaults.
// While the output register holds a word that is stalled, the whole chain
// holds and in_stall is raised; bubbles pass through when out_stall is low.
module adsr_envelope_level (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [adsr_pkg::P_W-1:0]       position,
    input  logic [31:0]                    sustain_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [adsr_pkg::LEVEL_W-1:0]   level,
    output logic [adsr_pkg::PHASE_W-1:0]   phase,
    output logic                           done_res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [adsr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [adsr_pkg::DATA_W-1:0]    cfg_data
);
    import adsr_pkg::*;

    cfg_t                cfg_reg;
    logic                en;
    cell_t               chain [0:LW];
    logic [LW-1:0]       lvl_next;
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic                done_reg;

    // The chain moves unless a finished word is waiting at the output.
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack      <= '0;
            cfg_reg.decay       <= '0;
            cfg_reg.release_len <= '0;
            cfg_reg.sustain     <= SUS_W'(FULL);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                IDX_ATTACK:  cfg_reg.attack      <= cfg_data[CW-1:0];
                IDX_DECAY:   cfg_reg.decay       <= cfg_data[CW-1:0];
                IDX_RELEASE: cfg_reg.release_len <= cfg_data[CW-1:0];
                IDX_SUSTAIN: cfg_reg.sustain     <= cfg_data[SUS_W-1:0];
                default:     ;
            endcase
        end
    end

    // Phase decode and multiply.
    adsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .position (position),
        .sus_len  (sustain_length[CW-1:0]),
        .cfg      (cfg_reg),
        .cell_out (chain[0])
    );

    // One cell per quotient bit, most significant first.
    for (genvar i = 0; i < LW; i++)
    begin : g_cell
        adsr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Final level from the quotient and the phase.
    always_comb
    begin
        case (chain[LW].side.phase)
            PH_ATTACK:  lvl_next = chain[LW].quot;
            PH_DECAY:   lvl_next = FULL - chain[LW].quot;
            PH_SUSTAIN: lvl_next = chain[LW].side.base;
            PH_RELEASE: lvl_next = chain[LW].quot;
            default:    lvl_next = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[LW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= LEVEL_W'(lvl_next);
            phase_reg <= chain[LW].side.phase;
            done_reg  <= (chain[LW].side.phase == PH_DONE);
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign phase     = phase_reg;
    assign done_res  = done_reg;

endmodule

### verif/envelope_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADSR envelope level checker
// Follows the register writes and the words accepted on the input channel,
// works out the envelope level, phase and done flag for each one, and
// compares the words leaving the block in order against those predictions.
// ----------------------------------------------------------------------------
module envelope_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [adsr_pkg::P_W-1:0]     position,
    input  logic [31:0]                  sustain_length,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [adsr_pkg::LEVEL_W-1:0] level,
    input  logic [adsr_pkg::PHASE_W-1:0] phase,
    input  logic                         done_res,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [adsr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [adsr_pkg::DATA_W-1:0]  cfg_data,
    output int                           mismatches,
    output int                           pending
);
    import adsr_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
        logic               done;
    } env_word_t;

    // Local copy of the envelope registers.
    logic [CW-1:0]    attack_len;
    logic [CW-1:0]    decay_len;
    logic [CW-1:0]    release_len;
    logic [SUS_W-1:0] sustain_val;

    env_word_t expected_words[$];
    int        mismatch_n = 0;

    // Envelope level at a position; all sums and products fit in 64 bits.
    function automatic env_word_t envelope_at(input logic [P_W-1:0] pos,
                                              input logic [31:0] sus_len);
        logic [63:0] p;
        logic [63:0] sat;
        logic [63:0] lvl;
        env_word_t   w;
        sat    = (sustain_val > FULL) ? 64'(FULL) : 64'(sustain_val);
        p      = 64'(pos);
        w.done = 1'b0;
        if (p < 64'(attack_len))
        begin
            lvl     = (p << LF) / 64'(attack_len);
            w.phase = PH_ATTACK;
        end
        else
        begin
            p = p - 64'(attack_len);
            if (p < 64'(decay_len))
            begin
                lvl     = 64'(FULL) - (p * (64'(FULL) - sat)) / 64'(decay_len);
                w.phase = PH_DECAY;
            end
            else
            begin
                p = p - 64'(decay_len);
                if (p < 64'(sus_len))
                begin
                    lvl     = sat;
                    w.phase = PH_SUSTAIN;
                end
                else
                begin
                    p = p - 64'(sus_len);
                    if (p < 64'(release_len))
                    begin
                        lvl     = (sat * (64'(release_len) - p)) / 64'(release_len);
                        w.phase = PH_RELEASE;
                    end
                    else
                    begin
                        // Beyond the end of the envelope the level reads zero.
                        lvl     = 64'd0;
                        w.phase = PH_DONE;
                        w.done  = 1'b1;
                    end
                end
            end
        end
        w.level = lvl[LEVEL_W-1:0];
        return w;
    endfunction

    // Track register writes, predict accepted input words, check output words.
    always @(posedge clk or negedge rst_n)
    begin : track
        env_word_t want;
        if (!rst_n)
        begin
            attack_len  = '0;
            decay_len   = '0;
            release_len = '0;
            sustain_val = FULL;
            expected_words.delete();
            pending    <= 0;
            mismatches <= mismatch_n;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    IDX_ATTACK:  attack_len  = cfg_data[CW-1:0];
                    IDX_DECAY:   decay_len   = cfg_data[CW-1:0];
                    IDX_RELEASE: release_len = cfg_data[CW-1:0];
                    IDX_SUSTAIN: sustain_val = cfg_data[SUS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_words.push_back(envelope_at(position, sustain_length));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("%0t: unexpected word level=%0d phase=%0d done=%0d",
                                 $realtime, level, phase, done_res);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (level !== want.level || phase !== want.phase ||
                        done_res !== want.done)
                    begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                        begin
                            $write("%0t: mismatch level %0d/%0d phase %0d/%0d",
                                   $realtime, want.level, level, want.phase, phase);
                            $display(" done %0d/%0d (expected/actual)",
                                     want.done, done_res);
                        end
                    end
                end
            end
            pending    <= expected_words.size();
            mismatches <= mismatch_n;
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADSR envelope level testbench
// Drives the envelope block through directed boundary cases and random words
// under several register settings, with random idling on both channels, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
    import adsr_pkg::*;

    localparam int          ITEM_TARGET  = 500;
    localparam int          LONG_HOLD    = 150;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [63:0] POS_SPAN     = 64'd1 << P_W;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic [P_W-1:0]       position       = '0;
    logic [31:0]          sustain_length = '0;
    logic                 out_stall      = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic [IDX_W-1:0]     cfg_index      = IDX_ATTACK;
    logic [DATA_W-1:0]    cfg_data       = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic [LEVEL_W-1:0]   level;
    logic [PHASE_W-1:0]   phase;
    logic                 done_res;
    logic                 cfg_ready;
    int                   mismatches;
    int                   pending;

    // Stimulus side view of the lengths currently programmed.
    logic [31:0] cur_attack  = '0;
    logic [31:0] cur_decay   = '0;
    logic [31:0] cur_release = '0;

    bit hold_req = 1'b0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int words_sent = 0;

    always #5 clk = ~clk;

    adsr_envelope_level i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .position       (position),
        .sustain_length (sustain_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .level          (level),
        .phase          (phase),
        .done_res       (done_res),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    envelope_checker i_envelope_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .position       (position),
        .sustain_length (sustain_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .level          (level),
        .phase          (phase),
        .done_res       (done_res),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // Idle length: mostly none, sometimes a few cycles, rarely a long pause.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Phase length classes: zero, short, medium, any 32-bit value, maximum.
    function automatic logic [31:0] random_length();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'd0;
            1, 2, 3: return $urandom_range(1, 16);
            4, 5, 6: return $urandom_range(17, 5000);
            7, 8:    return $urandom();
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Offer one word and hold it until accepted; valid stays high afterwards.
    task automatic send_word(input logic [P_W-1:0] pos, input logic [31:0] sus);
        in_valid       <= 1'b1;
        position       <= pos;
        sustain_length <= sus;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // Send a word, then maybe leave a gap before the next one.
    task automatic offer_word(input logic [P_W-1:0] pos, input logic [31:0] sus);
        int k;
        send_word(pos, sus);
        k = tx_quiet ? 0 : idle_cycles();
        if (k > 0)
        begin
            in_valid <= 1'b0;
            repeat (k) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted word has come out.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Program all four registers once the block has gone idle.
    task automatic apply_config(input logic [31:0] a, input logic [31:0] d,
                                input logic [31:0] r, input logic [31:0] s);
        settle();
        write_reg(IDX_ATTACK, a);
        write_reg(IDX_DECAY, d);
        write_reg(IDX_RELEASE, r);
        write_reg(IDX_SUSTAIN, s);
        cfg_valid   <= 1'b0;
        cur_attack  = a;
        cur_decay   = d;
        cur_release = r;
    endtask

    // Random setting; the sustain word sometimes carries junk above bit 16.
    task automatic random_config();
        logic [31:0] s;
        logic [31:0] junk;
        case ($urandom_range(0, 5))
            0:       s = 32'd0;
            1:       s = 32'd65536;
            2:       s = $urandom_range(65537, 131071);
            default: s = $urandom_range(0, 65536);
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            junk = $urandom();
            s    = {junk[31:SUS_W], s[SUS_W-1:0]};
        end
        apply_config(random_length(), random_length(), random_length(), s);
    endtask

    // Pick a position aimed at one phase, often on its first or last sample.
    task automatic random_word(output logic [P_W-1:0] pos, output logic [31:0] sus);
        logic [63:0] start;
        logic [63:0] span;
        logic [63:0] off;
        sus = random_length();
        if ($urandom_range(0, 9) == 0)
        begin
            off = {$urandom(), $urandom()};
            pos = off[P_W-1:0];
            sus = $urandom();
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    start = 64'd0;
                    span  = 64'(cur_attack);
                end
                1:
                begin
                    start = 64'(cur_attack);
                    span  = 64'(cur_decay);
                end
                2:
                begin
                    start = 64'(cur_attack) + 64'(cur_decay);
                    span  = 64'(sus);
                end
                3:
                begin
                    start = 64'(cur_attack) + 64'(cur_decay) + 64'(sus);
                    span  = 64'(cur_release);
                end
                default:
                begin
                    start = 64'(cur_attack) + 64'(cur_decay) + 64'(sus) + 64'(cur_release);
                    span  = POS_SPAN - start;
                end
            endcase
            if (span == 0)
                off = 64'd0;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       off = 64'd0;
                    1:       off = span - 64'd1;
                    default: off = {$urandom(), $urandom()} % span;
                endcase
            end
            off = start + off;
            pos = off[P_W-1:0];
        end
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold-off on request.
    initial
    begin : receiver
        int k;
        bit hold_taken;
        hold_taken = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 199) == 0)
                rx_quiet = ~rx_quiet;
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                k = rx_quiet ? 0 : idle_cycles();
                if (k > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (k) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Watchdog.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Main stimulus sequence.
    initial
    begin : stimulus
        logic [P_W-1:0] pos;
        logic [31:0]    sus;
        int             round;
        int             count;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting is a square envelope: full level while sustaining.
        offer_word(34'd0, 32'd0);
        offer_word(34'd0, 32'd5);
        offer_word(34'd4, 32'd5);
        offer_word(34'd5, 32'd5);
        offer_word(34'd0, 32'hFFFF_FFFF);
        offer_word({P_W{1'b1}}, 32'hFFFF_FFFF);

        // Ordinary envelope, first and last sample of every phase.
        apply_config(32'd100, 32'd50, 32'd200, 32'd30000);
        offer_word(34'd0, 32'd40);
        offer_word(34'd1, 32'd40);
        offer_word(34'd99, 32'd40);
        offer_word(34'd100, 32'd40);
        offer_word(34'd149, 32'd40);
        offer_word(34'd150, 32'd40);
        offer_word(34'd189, 32'd40);
        offer_word(34'd190, 32'd40);
        offer_word(34'd389, 32'd40);
        offer_word(34'd390, 32'd40);

        // Maximum lengths and a sustain level above full scale (saturates).
        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_FFFF);
        offer_word(34'd0, 32'hFFFF_FFFF);
        offer_word(34'h0_FFFF_FFFE, 32'hFFFF_FFFF);
        offer_word(34'h0_FFFF_FFFF, 32'hFFFF_FFFF);
        offer_word(34'h1_FFFF_FFFE, 32'hFFFF_FFFF);
        offer_word(34'h3_FFFF_FFFB, 32'hFFFF_FFFF);
        offer_word(34'h3_FFFF_FFFC, 32'hFFFF_FFFF);

        // Random rounds, each under a fresh setting.
        round = 0;
        while (words_sent < ITEM_TARGET)
        begin
            round++;
            if (round == 1)
                apply_config(32'd0, $urandom_range(1, 16), 32'd0, 32'd0);
            else
                random_config();
            tx_quiet = ($urandom_range(0, 3) == 0);
            count    = $urandom_range(40, 80);
            if (round == 2)
            begin
                // Long receiver hold-off while words keep coming back to back.
                hold_req = 1'b1;
                tx_quiet = 1'b1;
                count    = 120;
            end
            repeat (count)
            begin
                random_word(pos, sus);
                offer_word(pos, sus);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

### filelist.f
sv/adsr_pkg.sv
sv/adsr_front.sv
sv/adsr_div_cell.sv
sv/adsr_envelope_level.sv
verif/envelope_checker.sv
verif/tb_top.sv
